@@ src/keyed_duration_statistics_table_top_macros.svh @@
// Assertion macros for the keyed duration statistics table RTL.
`ifndef KEYED_DURATION_STATISTICS_TABLE_TOP_MACROS_SVH
`define KEYED_DURATION_STATISTICS_TABLE_TOP_MACROS_SVH
`ifndef ASSERT_OFF
// Checked on every rising clock edge, switched off while reset is high.
`define KDST_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked on every rising clock edge, reset included.
`define KDST_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define KDST_ASSERT(label, clk, rst, prop, msg)
`define KDST_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

@@ src/kdst_pkg.sv @@
// Types, widths and codes shared by the keyed duration statistics table.
package kdst_pkg;

   localparam int TABLE_ENTRIES_DEFAULT = 1024;

   localparam int STATUS_W = 3;
   localparam int SLOT_W   = 10;
   localparam int ID_W     = 32;
   localparam int DUR_W    = 48;
   localparam int COUNT_W  = 32;
   localparam int TOTAL_W  = 64;
   localparam int KEY_W    = 2 * ID_W;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
   localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

   localparam logic CMD_RECORD = 1'b0;
   localparam logic CMD_READ   = 1'b1;

   localparam logic [STATUS_W-1:0] ST_UPDATED    = 3'd0;
   localparam logic [STATUS_W-1:0] ST_INSERTED   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_ZERO       = 3'd2;
   localparam logic [STATUS_W-1:0] ST_OFF        = 3'd3;
   localparam logic [STATUS_W-1:0] ST_FULL       = 3'd4;
   localparam logic [STATUS_W-1:0] ST_READ_OK    = 3'd5;
   localparam logic [STATUS_W-1:0] ST_READ_EMPTY = 3'd6;

   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic [TOTAL_W-1:0] total;
      logic [DUR_W-1:0]   least;
      logic [DUR_W-1:0]   greatest;
   } stat_type;

endpackage

@@ src/kdst_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
module kdst_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/kdst_stat_update.sv @@
// Folds one duration into a slot's statistics: saturating count and total, min and max.
module kdst_stat_update (
   input  kdst_pkg::stat_type                old_stat,
   input  logic [kdst_pkg::DUR_W-1:0]        duration,
   output kdst_pkg::stat_type                new_stat
);

   logic [kdst_pkg::TOTAL_W:0] total_sum;

   assign total_sum = {1'b0, old_stat.total} + (kdst_pkg::TOTAL_W + 1)'(duration);

   always_comb begin
      new_stat = old_stat;
      if (old_stat.count != kdst_pkg::COUNT_MAX) begin
         new_stat.count = old_stat.count + 1'b1;
      end
      // A carry out of the total means it has passed all ones, so it sticks there.
      new_stat.total = total_sum[kdst_pkg::TOTAL_W] ? kdst_pkg::TOTAL_MAX
                                                    : total_sum[kdst_pkg::TOTAL_W-1:0];
      if (duration < old_stat.least) begin
         new_stat.least = duration;
      end
      if (duration > old_stat.greatest) begin
         new_stat.greatest = duration;
      end
   end

endmodule

@@ src/keyed_duration_statistics_table_top.sv @@
// Keyed duration statistics table: top level with control sequencer and both memories.
// Each record item is looked up by its (call site, thread tag) key with a linear
// search of the key memory, one slot per cycle over the slots filled so far, since
// slots are handed out in order of first appearance. Key reads are pipelined: a key
// that is found is followed by one read-modify-write of the statistics memory, and
// the result is then handed to the output register. A new key takes the next free
// slot; a record is dropped when the table is full, when capture is off or when its
// duration is zero; a read returns a filled slot or reports an empty one. One item
// is in flight at a time; the next is accepted once the previous result has moved
// to the output register, even while that result still waits to be taken. Slots in
// use are tracked by a fill count, so reset needs no clearing pass over the memories.
`include "keyed_duration_statistics_table_top_macros.svh"
module keyed_duration_statistics_table_top #(
   parameter int TABLE_ENTRIES = kdst_pkg::TABLE_ENTRIES_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,

   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_command,
   input  logic [kdst_pkg::ID_W-1:0]        req_call_site,
   input  logic [kdst_pkg::ID_W-1:0]        req_thread_tag,
   input  logic [kdst_pkg::DUR_W-1:0]       req_duration,
   input  logic [kdst_pkg::SLOT_W-1:0]      req_read_slot,

   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [kdst_pkg::STATUS_W-1:0]    rsp_status,
   output logic [kdst_pkg::SLOT_W-1:0]      rsp_slot,
   output logic [kdst_pkg::ID_W-1:0]        rsp_entry_call_site,
   output logic [kdst_pkg::ID_W-1:0]        rsp_entry_thread_tag,
   output logic [kdst_pkg::COUNT_W-1:0]     rsp_call_count,
   output logic [kdst_pkg::TOTAL_W-1:0]     rsp_total_duration,
   output logic [kdst_pkg::DUR_W-1:0]       rsp_least_duration,
   output logic [kdst_pkg::DUR_W-1:0]       rsp_greatest_duration,

   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic                             csr_capture_enable
);

   localparam int AW = $clog2(TABLE_ENTRIES);
   localparam int CW = AW + 1;
   localparam int SW = (AW > kdst_pkg::SLOT_W) ? AW : kdst_pkg::SLOT_W;
   localparam int RW = (CW > kdst_pkg::SLOT_W) ? CW : kdst_pkg::SLOT_W;
   localparam logic [CW-1:0] ENTRIES_C = CW'(TABLE_ENTRIES);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_READ   = 3'd1;
   localparam logic [2:0] S_SEARCH = 3'd2;
   localparam logic [2:0] S_UPDATE = 3'd3;
   localparam logic [2:0] S_INSERT = 3'd4;
   localparam logic [2:0] S_EMIT   = 3'd5;

   // Control state.
   logic [2:0]    state_ff, state_in;
   logic          capture_enable_ff, capture_enable_in;
   logic [CW-1:0] used_slots_ff, used_slots_in;
   logic          pending_ff, pending_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // Item and search payload.
   logic [CW-1:0]                 issue_ptr_ff, issue_ptr_in;
   logic [AW-1:0]                 cmp_slot_ff, cmp_slot_in;
   logic [AW-1:0]                 slot_ff, slot_in;
   logic [kdst_pkg::ID_W-1:0]     item_mid_ff, item_mid_in;
   logic [kdst_pkg::ID_W-1:0]     item_tid_ff, item_tid_in;
   logic [kdst_pkg::DUR_W-1:0]    item_dur_ff, item_dur_in;
   logic [kdst_pkg::SLOT_W-1:0]   item_rslot_ff, item_rslot_in;
   kdst_pkg::stat_type            old_stat_ff, old_stat_in;

   // Finished result, waiting for the output register.
   logic [kdst_pkg::STATUS_W-1:0] res_status_ff, res_status_in;
   logic [kdst_pkg::SLOT_W-1:0]   res_slot_ff, res_slot_in;
   logic [kdst_pkg::ID_W-1:0]     res_mid_ff, res_mid_in;
   logic [kdst_pkg::ID_W-1:0]     res_tid_ff, res_tid_in;
   kdst_pkg::stat_type            res_stat_ff, res_stat_in;

   // Output register.
   logic [kdst_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [kdst_pkg::SLOT_W-1:0]   rsp_slot_ff, rsp_slot_in;
   logic [kdst_pkg::ID_W-1:0]     rsp_mid_ff, rsp_mid_in;
   logic [kdst_pkg::ID_W-1:0]     rsp_tid_ff, rsp_tid_in;
   kdst_pkg::stat_type            rsp_stat_ff, rsp_stat_in;

   // Memory ports.
   logic                          mem_rd_en;
   logic [AW-1:0]                 mem_rd_addr;
   logic [AW-1:0]                 mem_wr_addr;
   logic                          key_wr_en;
   logic                          stat_wr_en;
   logic [kdst_pkg::KEY_W-1:0]    key_wr_data;
   logic [kdst_pkg::KEY_W-1:0]    key_rd_data;
   kdst_pkg::stat_type            stat_wr_data;
   kdst_pkg::stat_type            stat_rd_data;

   kdst_pkg::stat_type            new_stat;
   kdst_pkg::stat_type            insert_stat;
   logic                          req_accept;
   logic                          read_hit;
   logic [SW-1:0]                 req_slot_ext;
   logic [SW-1:0]                 slot_ext;
   logic                          search_more;
   logic                          key_match;
   logic                          emit_fire;

   kdst_ram #(
      .WIDTH (kdst_pkg::KEY_W),
      .DEPTH (TABLE_ENTRIES)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (key_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (key_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (key_rd_data)
   );

   kdst_ram #(
      .WIDTH ($bits(kdst_pkg::stat_type)),
      .DEPTH (TABLE_ENTRIES)
   ) u_stat_ram (
      .clock   (clock),
      .wr_en   (stat_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (stat_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (stat_rd_data)
   );

   kdst_stat_update u_stat_update (
      .old_stat (old_stat_ff),
      .duration (item_dur_ff),
      .new_stat (new_stat)
   );

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;

   // Filled slots are exactly those below the fill count.
   assign read_hit     = RW'(req_read_slot) < RW'(used_slots_ff);
   assign req_slot_ext = SW'(req_read_slot);
   assign slot_ext     = SW'(slot_ff);
   assign search_more  = issue_ptr_ff < used_slots_ff;
   assign key_match    = pending_ff && (key_rd_data == {item_mid_ff, item_tid_ff});
   assign emit_fire    = (state_ff == S_EMIT) && (!rsp_valid_ff || !rsp_stall);

   assign insert_stat.count    = kdst_pkg::COUNT_W'(1);
   assign insert_stat.total    = kdst_pkg::TOTAL_W'(item_dur_ff);
   assign insert_stat.least    = item_dur_ff;
   assign insert_stat.greatest = item_dur_ff;

   always_comb begin
      state_in          = state_ff;
      used_slots_in     = used_slots_ff;
      pending_in        = pending_ff;
      issue_ptr_in      = issue_ptr_ff;
      cmp_slot_in       = cmp_slot_ff;
      slot_in           = slot_ff;
      item_mid_in       = item_mid_ff;
      item_tid_in       = item_tid_ff;
      item_dur_in       = item_dur_ff;
      item_rslot_in     = item_rslot_ff;
      old_stat_in       = old_stat_ff;
      res_status_in     = res_status_ff;
      res_slot_in       = res_slot_ff;
      res_mid_in        = res_mid_ff;
      res_tid_in        = res_tid_ff;
      res_stat_in       = res_stat_ff;
      mem_rd_en         = 1'b0;
      mem_rd_addr       = issue_ptr_ff[AW-1:0];
      mem_wr_addr       = slot_ff;
      key_wr_en         = 1'b0;
      stat_wr_en        = 1'b0;
      key_wr_data       = {item_mid_ff, item_tid_ff};
      stat_wr_data      = new_stat;

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               item_mid_in   = req_call_site;
               item_tid_in   = req_thread_tag;
               item_dur_in   = req_duration;
               item_rslot_in = req_read_slot;
               res_slot_in   = '0;
               res_mid_in    = '0;
               res_tid_in    = '0;
               res_stat_in   = '0;
               if (req_command == kdst_pkg::CMD_READ) begin
                  if (read_hit) begin
                     mem_rd_en   = 1'b1;
                     mem_rd_addr = req_slot_ext[AW-1:0];
                     state_in    = S_READ;
                  end else begin
                     res_status_in = kdst_pkg::ST_READ_EMPTY;
                     res_slot_in   = req_read_slot;
                     state_in      = S_EMIT;
                  end
               end else if (!capture_enable_ff) begin
                  res_status_in = kdst_pkg::ST_OFF;
                  state_in      = S_EMIT;
               end else if (req_duration == '0) begin
                  res_status_in = kdst_pkg::ST_ZERO;
                  state_in      = S_EMIT;
               end else begin
                  issue_ptr_in = '0;
                  pending_in   = 1'b0;
                  state_in     = S_SEARCH;
               end
            end
         end
         S_READ: begin
            res_status_in = kdst_pkg::ST_READ_OK;
            res_slot_in   = item_rslot_ff;
            res_mid_in    = key_rd_data[kdst_pkg::KEY_W-1:kdst_pkg::ID_W];
            res_tid_in    = key_rd_data[kdst_pkg::ID_W-1:0];
            res_stat_in   = stat_rd_data;
            state_in      = S_EMIT;
         end
         S_SEARCH: begin
            // One slot is issued per cycle; its key is compared when the read returns.
            if (key_match) begin
               old_stat_in = stat_rd_data;
               slot_in     = cmp_slot_ff;
               pending_in  = 1'b0;
               state_in    = S_UPDATE;
            end else if (search_more) begin
               mem_rd_en    = 1'b1;
               mem_rd_addr  = issue_ptr_ff[AW-1:0];
               pending_in   = 1'b1;
               cmp_slot_in  = issue_ptr_ff[AW-1:0];
               issue_ptr_in = issue_ptr_ff + 1'b1;
            end else if (pending_ff) begin
               pending_in = 1'b0;
            end else if (used_slots_ff >= ENTRIES_C) begin
               res_status_in = kdst_pkg::ST_FULL;
               res_slot_in   = '0;
               res_mid_in    = item_mid_ff;
               res_tid_in    = item_tid_ff;
               res_stat_in   = '0;
               state_in      = S_EMIT;
            end else begin
               slot_in  = used_slots_ff[AW-1:0];
               state_in = S_INSERT;
            end
         end
         S_UPDATE: begin
            stat_wr_en    = 1'b1;
            res_status_in = kdst_pkg::ST_UPDATED;
            res_slot_in   = slot_ext[kdst_pkg::SLOT_W-1:0];
            res_mid_in    = item_mid_ff;
            res_tid_in    = item_tid_ff;
            res_stat_in   = new_stat;
            state_in      = S_EMIT;
         end
         S_INSERT: begin
            key_wr_en     = 1'b1;
            stat_wr_en    = 1'b1;
            stat_wr_data  = insert_stat;
            used_slots_in = used_slots_ff + 1'b1;
            res_status_in = kdst_pkg::ST_INSERTED;
            res_slot_in   = slot_ext[kdst_pkg::SLOT_W-1:0];
            res_mid_in    = item_mid_ff;
            res_tid_in    = item_tid_ff;
            res_stat_in   = insert_stat;
            state_in      = S_EMIT;
         end
         S_EMIT: begin
            if (emit_fire) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in  = emit_fire || (rsp_valid_ff && rsp_stall);
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_mid_in    = rsp_mid_ff;
      rsp_tid_in    = rsp_tid_ff;
      rsp_stat_in   = rsp_stat_ff;
      if (emit_fire) begin
         rsp_status_in = res_status_ff;
         rsp_slot_in   = res_slot_ff;
         rsp_mid_in    = res_mid_ff;
         rsp_tid_in    = res_tid_ff;
         rsp_stat_in   = res_stat_ff;
      end
   end

   always_comb begin
      capture_enable_in = capture_enable_ff;
      if (csr_valid && csr_ready) begin
         capture_enable_in = csr_capture_enable;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= S_IDLE;
         capture_enable_ff <= 1'b1;
         used_slots_ff     <= '0;
         pending_ff        <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         state_ff          <= state_in;
         capture_enable_ff <= capture_enable_in;
         used_slots_ff     <= used_slots_in;
         pending_ff        <= pending_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      issue_ptr_ff  <= issue_ptr_in;
      cmp_slot_ff   <= cmp_slot_in;
      slot_ff       <= slot_in;
      item_mid_ff   <= item_mid_in;
      item_tid_ff   <= item_tid_in;
      item_dur_ff   <= item_dur_in;
      item_rslot_ff <= item_rslot_in;
      old_stat_ff   <= old_stat_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      res_mid_ff    <= res_mid_in;
      res_tid_ff    <= res_tid_in;
      res_stat_ff   <= res_stat_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_mid_ff    <= rsp_mid_in;
      rsp_tid_ff    <= rsp_tid_in;
      rsp_stat_ff   <= rsp_stat_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_status            = rsp_status_ff;
   assign rsp_slot              = rsp_slot_ff;
   assign rsp_entry_call_site   = rsp_mid_ff;
   assign rsp_entry_thread_tag  = rsp_tid_ff;
   assign rsp_call_count        = rsp_stat_ff.count;
   assign rsp_total_duration    = rsp_stat_ff.total;
   assign rsp_least_duration    = rsp_stat_ff.least;
   assign rsp_greatest_duration = rsp_stat_ff.greatest;

   // After reset the sequencer is idle, nothing is offered and the table is empty.
   `KDST_ASSERT_ALWAYS(a_reset_clears, clock, reset |=> (state_ff == S_IDLE && !rsp_valid_ff && used_slots_ff == '0), "reset did not clear the control state")
   // The fill count never runs past the table size.
   `KDST_ASSERT(a_fill_bounded, clock, reset, used_slots_ff <= ENTRIES_C, "fill count exceeds the table size")
   // An insert takes exactly one new slot.
   `KDST_ASSERT(a_insert_counts, clock, reset, (state_ff == S_INSERT) |=> (used_slots_ff == $past(used_slots_ff) + 1'b1), "insert did not advance the fill count by one")
   // A key under comparison always comes from a filled slot.
   `KDST_ASSERT(a_compare_in_range, clock, reset, (state_ff == S_SEARCH && pending_ff) |-> ({1'b0, cmp_slot_ff} < used_slots_ff), "search compared a slot beyond the fill count")
   // A finished item reaches the output register and frees the input side.
   `KDST_ASSERT(a_emit_lands, clock, reset, emit_fire |=> (rsp_valid_ff && state_ff == S_IDLE), "result was not moved to the output register")

endmodule

@@ tb/sv/keyed_duration_statistics_table_top_tb.sv @@
// Self-checking testbench for the keyed duration statistics table top level.
module keyed_duration_statistics_table_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TABLE_ENTRIES = kdst_pkg::TABLE_ENTRIES_DEFAULT;
   localparam int QUIET_LIMIT   = 20000;
   localparam int SETTLE_CYCLES = 40;

   localparam int STATUS_W = kdst_pkg::STATUS_W;
   localparam int SLOT_W   = kdst_pkg::SLOT_W;
   localparam int ID_W     = kdst_pkg::ID_W;
   localparam int DUR_W    = kdst_pkg::DUR_W;
   localparam int COUNT_W  = kdst_pkg::COUNT_W;
   localparam int TOTAL_W  = kdst_pkg::TOTAL_W;
   localparam int KEY_W    = kdst_pkg::KEY_W;

   typedef struct packed {
      logic               command;
      logic [ID_W-1:0]    call_site;
      logic [ID_W-1:0]    thread_tag;
      logic [DUR_W-1:0]   duration;
      logic [SLOT_W-1:0]  read_slot;
   } request_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0]   slot;
      logic [ID_W-1:0]     call_site;
      logic [ID_W-1:0]     thread_tag;
      logic [COUNT_W-1:0]  call_count;
      logic [TOTAL_W-1:0]  total;
      logic [DUR_W-1:0]    least;
      logic [DUR_W-1:0]    greatest;
   } result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                req_valid      = 1'b0;
   logic                req_stall;
   logic                req_command    = kdst_pkg::CMD_RECORD;
   logic [ID_W-1:0]     req_call_site  = '0;
   logic [ID_W-1:0]     req_thread_tag = '0;
   logic [DUR_W-1:0]    req_duration   = '0;
   logic [SLOT_W-1:0]   req_read_slot  = '0;

   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic [SLOT_W-1:0]   rsp_slot;
   logic [ID_W-1:0]     rsp_entry_call_site;
   logic [ID_W-1:0]     rsp_entry_thread_tag;
   logic [COUNT_W-1:0]  rsp_call_count;
   logic [TOTAL_W-1:0]  rsp_total_duration;
   logic [DUR_W-1:0]    rsp_least_duration;
   logic [DUR_W-1:0]    rsp_greatest_duration;

   logic                csr_valid          = 1'b0;
   logic                csr_ready;
   logic                csr_capture_enable = 1'b1;

   keyed_duration_statistics_table_top #(
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_command           (req_command),
      .req_call_site         (req_call_site),
      .req_thread_tag        (req_thread_tag),
      .req_duration          (req_duration),
      .req_read_slot         (req_read_slot),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_status            (rsp_status),
      .rsp_slot              (rsp_slot),
      .rsp_entry_call_site   (rsp_entry_call_site),
      .rsp_entry_thread_tag  (rsp_entry_thread_tag),
      .rsp_call_count        (rsp_call_count),
      .rsp_total_duration    (rsp_total_duration),
      .rsp_least_duration    (rsp_least_duration),
      .rsp_greatest_duration (rsp_greatest_duration),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_capture_enable    (csr_capture_enable)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Shadow of the statistics table; slots below fill_count are the filled ones.
   logic [KEY_W-1:0]   key_mem      [TABLE_ENTRIES];
   logic [COUNT_W-1:0] count_mem    [TABLE_ENTRIES];
   logic [TOTAL_W-1:0] total_mem    [TABLE_ENTRIES];
   logic [DUR_W-1:0]   least_mem    [TABLE_ENTRIES];
   logic [DUR_W-1:0]   greatest_mem [TABLE_ENTRIES];
   int                 fill_count = 0;
   logic               capture_on = 1'b1;

   request_type command_queue[$];
   result_type  expected_stats[$];
   logic [KEY_W-1:0] key_pool[$];
   bit known_keys[bit [KEY_W-1:0]];

   request_type on_wire;
   int send_gap    = 0;
   int send_calm   = 0;
   int stall_left  = 0;
   int stall_calm  = 0;
   int quiet_cycles = 0;
   int mismatch_count = 0;

   function automatic result_type slot_contents(logic [STATUS_W-1:0] status, int s);
      result_type rs;
      rs.status     = status;
      rs.slot       = SLOT_W'(s);
      rs.call_site  = key_mem[s][KEY_W-1:ID_W];
      rs.thread_tag = key_mem[s][ID_W-1:0];
      rs.call_count = count_mem[s];
      rs.total      = total_mem[s];
      rs.least      = least_mem[s];
      rs.greatest   = greatest_mem[s];
      return rs;
   endfunction

   function automatic result_type tally_request(request_type rq);
      result_type       rs;
      logic [KEY_W-1:0] key;
      logic [TOTAL_W:0] sum;
      int               s;
      rs = '0;
      key = {rq.call_site, rq.thread_tag};
      if (rq.command == kdst_pkg::CMD_READ) begin
         if (int'(rq.read_slot) < fill_count) begin
            return slot_contents(kdst_pkg::ST_READ_OK, int'(rq.read_slot));
         end
         rs.status = kdst_pkg::ST_READ_EMPTY;
         rs.slot   = rq.read_slot;
         return rs;
      end
      // Capture off takes precedence over a zero duration.
      if (!capture_on) begin
         rs.status = kdst_pkg::ST_OFF;
         return rs;
      end
      if (rq.duration == '0) begin
         rs.status = kdst_pkg::ST_ZERO;
         return rs;
      end
      for (s = 0; s < fill_count; s++) begin
         if (key_mem[s] == key) begin
            if (count_mem[s] != kdst_pkg::COUNT_MAX) count_mem[s] = count_mem[s] + 1'b1;
            sum = {1'b0, total_mem[s]} + (TOTAL_W + 1)'(rq.duration);
            total_mem[s] = sum[TOTAL_W] ? kdst_pkg::TOTAL_MAX : sum[TOTAL_W-1:0];
            if (rq.duration < least_mem[s]) least_mem[s] = rq.duration;
            if (rq.duration > greatest_mem[s]) greatest_mem[s] = rq.duration;
            return slot_contents(kdst_pkg::ST_UPDATED, s);
         end
      end
      if (fill_count >= TABLE_ENTRIES) begin
         rs.status     = kdst_pkg::ST_FULL;
         rs.call_site  = rq.call_site;
         rs.thread_tag = rq.thread_tag;
         return rs;
      end
      s = fill_count;
      fill_count++;
      key_mem[s]      = key;
      count_mem[s]    = COUNT_W'(1);
      total_mem[s]    = TOTAL_W'(rq.duration);
      least_mem[s]    = rq.duration;
      greatest_mem[s] = rq.duration;
      return slot_contents(kdst_pkg::ST_INSERTED, s);
   endfunction

   function automatic int idle_length();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 45) return 0;
      if (pick < 80) return $urandom_range(1, 3);
      if (pick < 96) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [DUR_W-1:0] random_duration();
      logic [63:0] w;
      int          pick;
      w = {$urandom(), $urandom()};
      pick = $urandom_range(0, 99);
      if (pick < 35) return w[DUR_W-1:0];
      if (pick < 55) return DUR_W'($urandom_range(1, 1000));
      if (pick < 65) return '1;
      if (pick < 72) return DUR_W'(1);
      return (w[DUR_W-1:0] >> $urandom_range(0, DUR_W - 1)) | DUR_W'(1);
   endfunction

   // Some new keys share one half with a known key, so that both halves of the
   // comparison are exercised.
   function automatic logic [KEY_W-1:0] fresh_key();
      logic [KEY_W-1:0] k;
      logic [KEY_W-1:0] near;
      do begin
         k = {$urandom(), $urandom()};
         if (key_pool.size() > 0 && $urandom_range(0, 3) == 0) begin
            near = key_pool[$urandom_range(0, key_pool.size() - 1)];
            if ($urandom_range(0, 1) == 1) k[KEY_W-1:ID_W] = near[KEY_W-1:ID_W];
            else k[ID_W-1:0] = near[ID_W-1:0];
         end
      end while (known_keys.exists(k));
      known_keys[k] = 1'b1;
      key_pool.push_back(k);
      return k;
   endfunction

   function automatic int pick_slot();
      int top;
      top = (key_pool.size() + 2 > 1023) ? 1023 : key_pool.size() + 2;
      if ($urandom_range(0, 9) < 7) return $urandom_range(0, top);
      return $urandom_range(0, 1023);
   endfunction

   task automatic push_record(input logic [KEY_W-1:0] key, input logic [DUR_W-1:0] dur);
      request_type rq;
      if (!known_keys.exists(key)) begin
         known_keys[key] = 1'b1;
         key_pool.push_back(key);
      end
      rq.command    = kdst_pkg::CMD_RECORD;
      rq.call_site  = key[KEY_W-1:ID_W];
      rq.thread_tag = key[ID_W-1:0];
      rq.duration   = dur;
      rq.read_slot  = SLOT_W'($urandom());
      command_queue.push_back(rq);
   endtask

   task automatic push_read(input int slot);
      request_type rq;
      logic [63:0] w;
      w = {$urandom(), $urandom()};
      rq.command    = kdst_pkg::CMD_READ;
      rq.call_site  = $urandom();
      rq.thread_tag = $urandom();
      rq.duration   = w[DUR_W-1:0];
      rq.read_slot  = SLOT_W'(slot);
      command_queue.push_back(rq);
   endtask

   task automatic random_mix(input int n, input int fresh_pct);
      int               i;
      int               pick;
      logic [KEY_W-1:0] key;
      for (i = 0; i < n; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 25) begin
            push_read(pick_slot());
         end else begin
            if (key_pool.size() == 0 || $urandom_range(0, 99) < fresh_pct) key = fresh_key();
            else key = key_pool[$urandom_range(0, key_pool.size() - 1)];
            push_record(key, (pick < 32) ? {DUR_W{1'b0}} : random_duration());
         end
      end
   endtask

   // Mostly new keys until every slot is taken, with some updates and reads mixed in.
   task automatic fill_table();
      int inserts_due;
      int pick;
      inserts_due = TABLE_ENTRIES - fill_count;
      while (inserts_due > 0) begin
         pick = $urandom_range(0, 99);
         if (pick < 97) begin
            push_record(fresh_key(), random_duration());
            inserts_due--;
         end else if (pick < 99) begin
            push_record(key_pool[$urandom_range(0, key_pool.size() - 1)], random_duration());
         end else begin
            push_read($urandom_range(0, 1023));
         end
      end
   endtask

   task automatic wait_for_results();
      do @(negedge clock);
      while (command_queue.size() != 0 || req_valid || expected_stats.size() != 0);
   endtask

   task automatic write_capture(input logic value);
      @(posedge clock);
      csr_valid          <= 1'b1;
      csr_capture_enable <= value;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid  <= 1'b0;
      capture_on = value;
   endtask

   function automatic void compare_field(string field, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("%0t ns: %s expected %0h, got %0h", $time, field, want, got);
      end
   endfunction

   // Driver: presents the pending items and predicts each one as it is taken.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) expected_stats.push_back(tally_request(on_wire));
         if (!req_valid || !req_stall) begin
            if (send_gap > 0 || command_queue.size() == 0) begin
               req_valid <= 1'b0;
               if (send_gap > 0) send_gap--;
            end else begin
               on_wire = command_queue.pop_front();
               req_valid      <= 1'b1;
               req_command    <= on_wire.command;
               req_call_site  <= on_wire.call_site;
               req_thread_tag <= on_wire.thread_tag;
               req_duration   <= on_wire.duration;
               req_read_slot  <= on_wire.read_slot;
               if (send_calm > 0) begin
                  send_calm--;
                  send_gap = 0;
               end else begin
                  send_gap = idle_length();
                  if ($urandom_range(0, 39) == 0) send_calm = $urandom_range(10, 40);
               end
            end
         end
      end
   end

   // Monitor: checks every result taken against the oldest prediction.
   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_stats.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t ns: result with no item outstanding", $time);
            end else begin
               want = expected_stats.pop_front();
               compare_field("status", 64'(want.status), 64'(rsp_status));
               compare_field("slot", 64'(want.slot), 64'(rsp_slot));
               compare_field("call_site", 64'(want.call_site), 64'(rsp_entry_call_site));
               compare_field("thread_tag", 64'(want.thread_tag), 64'(rsp_entry_thread_tag));
               compare_field("call_count", 64'(want.call_count), 64'(rsp_call_count));
               compare_field("total_duration", want.total, rsp_total_duration);
               compare_field("least_duration", 64'(want.least), 64'(rsp_least_duration));
               compare_field("greatest_duration", 64'(want.greatest),
                             64'(rsp_greatest_duration));
            end
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
            if (stall_calm > 0) stall_calm--;
            else if ($urandom_range(0, 3) == 0) stall_left = idle_length();
            else if ($urandom_range(0, 49) == 0) stall_calm = $urandom_range(20, 80);
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles = 0;
      end else if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)
                   || (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      write_capture(1'b1);

      // Extreme keys and durations, repeat hits, a zero duration and reads.
      push_record('0, DUR_W'(1));
      push_record('1, '1);
      push_record('0, '1);
      push_record('0, DUR_W'(5));
      push_record('1, DUR_W'(1));
      push_record({{ID_W{1'b0}}, {ID_W{1'b1}}}, '0);
      push_record({{ID_W{1'b1}}, {ID_W{1'b0}}}, DUR_W'(7));
      push_record({{ID_W{1'b0}}, {ID_W{1'b1}}}, DUR_W'(9));
      push_read(0);
      push_read(3);
      push_read(4);
      push_read(1023);
      push_read(2);
      wait_for_results();

      // With capture off, records are refused even with zero duration; reads still work.
      write_capture(1'b0);
      push_record('0, DUR_W'(100));
      push_record({32'h0000_0001, {ID_W{1'b0}}}, '0);
      push_read(1);
      push_read(1023);
      wait_for_results();

      write_capture(1'b1);
      push_record('0, '0);
      push_read(0);
      wait_for_results();

      random_mix(30, 30);
      wait_for_results();
      write_capture(1'b0);
      random_mix(8, 20);
      wait_for_results();
      write_capture(1'b1);
      random_mix(24, 25);
      wait_for_results();

      fill_table();
      wait_for_results();

      // The table is now full: new keys are dropped, known keys still update.
      random_mix(16, 40);
      wait_for_results();
      write_capture(1'b0);
      random_mix(6, 30);
      wait_for_results();

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+src
src/kdst_pkg.sv
src/kdst_ram.sv
src/kdst_stat_update.sv
src/keyed_duration_statistics_table_top.sv
tb/sv/keyed_duration_statistics_table_top_tb.sv
